/* src/bmpu_pkg.sv */
// Shared types and constants for the bit-field pixel unpacker.
package bmpu_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned OutW    = 8;
	localparam int unsigned NumChan = 4;
	localparam int unsigned IdxW    = 3;
	localparam int unsigned DepthW  = 6;

	// Register map of the configuration port
	typedef enum logic [IdxW-1:0] {
		REG_RED_MASK    = 3'd0,
		REG_GREEN_MASK  = 3'd1,
		REG_BLUE_MASK   = 3'd2,
		REG_ALPHA_MASK  = 3'd3,
		REG_PIXEL_DEPTH = 3'd4
	} reg_idx_t;

	localparam logic [DepthW-1:0] DEPTH_16    = 6'd16;
	localparam logic [DepthW-1:0] DEPTH_32    = 6'd32;
	localparam logic [DepthW-1:0] DEPTH_RESET = 6'd32;

	// Per-channel settings: mask plus values derived from it at write time
	typedef struct packed {
		logic [WordW-1:0] mask;
		logic [4:0]       lsb;    // lowest set bit of mask
		logic [5:0]       width;  // set bits in mask, 0..32
	} chan_cfg_t;

endpackage

/* src/bitfield_mask_pixel_unpack_top.sv */
// Top level of the bit-field pixel unpacker: one raw word in, one RGBA8 word out.
//
// Decodes one raw pixel word into red, green, blue and alpha, eight bits each,
// using four channel masks and a pixel depth set through the write port
// (index 0..3 the red, green, blue and alpha masks, 4 the depth; other indices
// are ignored). Depth 16 decodes the low half of the word, depth 32 the whole
// word, any other depth gives all-zero colour; a zero mask gives zero for that
// channel. Fields wider than eight bits are truncated, narrower ones shifted up
// with their new low bits set to ones when the result is non-zero. A word is
// captured in the input register at the edge that accepts it, decoded in one
// combinational pass and loaded into the output register at the next edge at
// which that register is free or being emptied, which raises output valid. One
// word is taken per cycle when the consumer keeps up; while a finished word
// waits in the output register, one further word is taken into the input
// register, after which input ready stays low until the output is taken. Bit
// counts and lowest set bits of the masks are worked out when a mask is
// written, so write configuration only while no word is in flight.
module bitfield_mask_pixel_unpack_top
	import bmpu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [IdxW-1:0]    cfg_index,
	input  logic [WordW-1:0]   cfg_data,
	// input word
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WordW-1:0]   pixel_word,
	// output word
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OutW-1:0]    red_out,
	output logic [OutW-1:0]    green_out,
	output logic [OutW-1:0]    blue_out,
	output logic [OutW-1:0]    alpha_out
);

	chan_cfg_t         chan_cfg [NumChan];
	logic [DepthW-1:0] depth;

	logic              valid_s1;
	logic [WordW-1:0]  pixel_s1;
	logic              valid_s2;
	logic [OutW-1:0]   chan_s2 [NumChan];

	logic              adv_s1;
	logic              free_s2;
	logic [WordW-1:0]  word;
	logic [OutW-1:0]   chan_val [NumChan];

	bmpu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chan_cfg  (chan_cfg),
		.depth     (depth)
	);

	// handshake: output register frees when taken, input stage moves into it
	assign free_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && free_s2;
	assign in_ready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= pixel_word;
		end
	end

	// depth select: low half at 16 bpp, whole word at 32, else zero
	always_comb begin
		if (depth == DEPTH_16) begin
			word = {16'h0000, pixel_s1[15:0]};
		end else if (depth == DEPTH_32) begin
			word = pixel_s1;
		end else begin
			word = '0;
		end
	end

	for (genvar c = 0; c < NumChan; c++) begin : g_chan
		bmpu_chan u_chan (
			.word  (word),
			.cfg   (chan_cfg[c]),
			.value (chan_val[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chan_s2 <= chan_val;
		end
	end

	assign out_valid = valid_s2;
	assign red_out   = chan_s2[0];
	assign green_out = chan_s2[1];
	assign blue_out  = chan_s2[2];
	assign alpha_out = chan_s2[3];

endmodule

/* src/bmpu_cfg.sv */
// Configuration registers, with per-mask bit count and lowest set bit.
module bmpu_cfg
	import bmpu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IdxW-1:0]        cfg_index,
	input  logic [WordW-1:0]       cfg_data,
	output chan_cfg_t              chan_cfg [NumChan],
	output logic [DepthW-1:0]      depth
);

	function automatic logic [5:0] pop_count(input logic [WordW-1:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < WordW; i++) begin
			n = n + 6'(v[i]);
		end
		return n;
	endfunction

	function automatic logic [4:0] low_bit(input logic [WordW-1:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	chan_cfg_t         chan_q [NumChan];
	logic [DepthW-1:0] depth_q;
	chan_cfg_t         wr_cfg;

	always_comb begin
		wr_cfg.mask  = cfg_data;
		wr_cfg.lsb   = low_bit(cfg_data);
		wr_cfg.width = pop_count(cfg_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumChan; c++) begin
				chan_q[c] <= '0;
			end
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RED_MASK:    chan_q[0] <= wr_cfg;
				REG_GREEN_MASK:  chan_q[1] <= wr_cfg;
				REG_BLUE_MASK:   chan_q[2] <= wr_cfg;
				REG_ALPHA_MASK:  chan_q[3] <= wr_cfg;
				REG_PIXEL_DEPTH: depth_q   <= cfg_data[DepthW-1:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	assign chan_cfg = chan_q;
	assign depth    = depth_q;

endmodule

/* src/bmpu_chan.sv */
// One channel: mask, align to bit 0 and scale to eight bits.
module bmpu_chan
	import bmpu_pkg::*;
(
	input  logic [WordW-1:0] word,
	input  chan_cfg_t        cfg,
	output logic [OutW-1:0]  value
);

	logic [WordW-1:0] field;
	logic [WordW-1:0] narrow;
	logic [WordW-1:0] wide;
	logic [3:0]       up_amt;
	logic [4:0]       down_amt;
	logic [OutW-1:0]  fill;

	always_comb begin
		field    = (word & cfg.mask) >> cfg.lsb;
		down_amt = 5'(cfg.width - 6'd8);
		up_amt   = 4'(6'd8 - cfg.width);
		wide     = field >> down_amt;
		narrow   = field << up_amt;
		// ones in the low bits opened by the left shift, only if non-zero
		fill     = (narrow != '0) ? 8'((9'd1 << up_amt) - 9'd1) : '0;
		if (cfg.width > 6'd8) begin
			value = wide[OutW-1:0];
		end else begin
			value = narrow[OutW-1:0] | fill;
		end
	end

endmodule

/* bench/tb_bitfield_mask_pixel_unpack_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bit-field pixel unpacker top level.
module tb_bitfield_mask_pixel_unpack_top;
	import bmpu_pkg::*;

	// Output pixel as four eight-bit channels
	typedef struct packed {
		logic [OutW-1:0] red;
		logic [OutW-1:0] green;
		logic [OutW-1:0] blue;
		logic [OutW-1:0] alpha;
	} rgba_t;

	// Tracks the register settings as written, predicts one RGBA word per
	// accepted raw word and compares in order against what comes out.
	class rgba_tracker;
		logic [WordW-1:0]  chan_mask [NumChan];
		logic [DepthW-1:0] depth;
		rgba_t             expected_pixels [$];
		int                errors;

		function new();
			foreach (chan_mask[i])
				chan_mask[i] = '0;
			depth  = DEPTH_RESET;
			errors = 0;
		endfunction

		// Indices outside the register map are dropped, as the block does
		function void set_reg(logic [IdxW-1:0] idx, logic [WordW-1:0] data);
			case (reg_idx_t'(idx))
				REG_RED_MASK:    chan_mask[0] = data;
				REG_GREEN_MASK:  chan_mask[1] = data;
				REG_BLUE_MASK:   chan_mask[2] = data;
				REG_ALPHA_MASK:  chan_mask[3] = data;
				REG_PIXEL_DEPTH: depth = data[DepthW-1:0];
				default: ;
			endcase
		endfunction

		// Extract one channel and bring it to eight bits
		function logic [OutW-1:0] scale_field(logic [WordW-1:0] w, logic [WordW-1:0] m);
			int unsigned      nbits = 0;
			int unsigned      lsb = 0;
			logic [WordW-1:0] f;
			if (m == '0)
				return '0;
			for (int i = WordW - 1; i >= 0; i--) begin
				if (m[i]) begin
					nbits++;
					lsb = i;
				end
			end
			f = (w & m) >> lsb;
			if (nbits > OutW) begin
				f = f >> (nbits - OutW);
			end else begin
				// widen; vacated low bits become ones unless the value is zero
				f = f << (OutW - nbits);
				if (f != '0)
					f = f | ((WordW'(1) << (OutW - nbits)) - 1);
			end
			return f[OutW-1:0];
		endfunction

		function rgba_t decode_pixel(logic [WordW-1:0] raw);
			logic [WordW-1:0] w;
			rgba_t            px;
			if (depth == DEPTH_16)
				w = raw & 32'h0000_FFFF;
			else if (depth == DEPTH_32)
				w = raw;
			else
				w = '0;
			px.red   = scale_field(w, chan_mask[0]);
			px.green = scale_field(w, chan_mask[1]);
			px.blue  = scale_field(w, chan_mask[2]);
			px.alpha = scale_field(w, chan_mask[3]);
			return px;
		endfunction

		function void note_word(logic [WordW-1:0] raw);
			expected_pixels.push_back(decode_pixel(raw));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH @%0t: %s", $realtime, what);
			errors++;
		endtask

		task check_pixel(rgba_t got);
			rgba_t exp_px;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", got));
				return;
			end
			exp_px = expected_pixels.pop_front();
			if (got.red !== exp_px.red)
				report_mismatch($sformatf("red %h, want %h", got.red, exp_px.red));
			if (got.green !== exp_px.green)
				report_mismatch($sformatf("green %h, want %h", got.green, exp_px.green));
			if (got.blue !== exp_px.blue)
				report_mismatch($sformatf("blue %h, want %h", got.blue, exp_px.blue));
			if (got.alpha !== exp_px.alpha)
				report_mismatch($sformatf("alpha %h, want %h", got.alpha, exp_px.alpha));
		endtask
	endclass

	// Clock, reset and the block's inputs, all known from time zero
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IdxW-1:0]  cfg_index = '0;
	logic [WordW-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic [WordW-1:0] pixel_word = '0;
	logic             out_ready = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic [OutW-1:0]  red_out;
	logic [OutW-1:0]  green_out;
	logic [OutW-1:0]  blue_out;
	logic [OutW-1:0]  alpha_out;

	// Idle rates in percent, changed per phase of the run
	int send_idle_pct = 16;
	int recv_stall_pct = 65;

	rgba_tracker sb = new();

	bitfield_mask_pixel_unpack_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_word(pixel_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Safety net: far beyond the slowest legitimate run (~1800 words)
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Consumer back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitors: everything sampled on the rising edge, before the block's
	// own register updates land, so the handshake view is race-free.
	always @(posedge clk) begin
		if (cfg_we)
			sb.set_reg(cfg_index, cfg_data);
		if (arst_n && in_valid && in_ready)
			sb.note_word(pixel_word);
		if (arst_n && out_valid && out_ready)
			sb.check_pixel({red_out, green_out, blue_out, alpha_out});
	end

	// Offer one raw word, with random idle cycles in front; returns on the
	// edge at which it is taken. Valid stays up across back-to-back words.
	task automatic send_word(input logic [WordW-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		pixel_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait for every predicted word to come back, then let the two-stage
	// pipe settle; bounded so a stuck block still reaches the end check.
	task automatic drain_results();
		int n = 0;
		while (sb.pending() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IdxW-1:0] idx, input logic [WordW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// Full register set; a stray write to an unmapped index sits in the
	// middle and must leave everything alone. Only called with the pipe empty.
	task automatic apply_config(input logic [WordW-1:0] rm, input logic [WordW-1:0] gm,
			input logic [WordW-1:0] bm, input logic [WordW-1:0] am,
			input logic [DepthW-1:0] dep);
		put_reg(REG_RED_MASK, rm);
		put_reg(REG_GREEN_MASK, gm);
		put_reg(IdxW'($urandom_range(2**IdxW - 1, int'(REG_PIXEL_DEPTH) + 1)), $urandom);
		put_reg(REG_BLUE_MASK, bm);
		put_reg(REG_ALPHA_MASK, am);
		put_reg(REG_PIXEL_DEPTH, WordW'(dep));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mask mix: empty, full, scattered bits, a lone bit, or a contiguous run
	// kept within span so 16-bit depth gets meaningful fields.
	function automatic logic [WordW-1:0] rand_mask(input int unsigned span);
		int unsigned w;
		int unsigned lsb;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			3: return WordW'(1) << $urandom_range(span - 1);
			default: begin
				w   = $urandom_range(span, 1);
				lsb = $urandom_range(span - w);
				return ((w == WordW) ? '1 : ((WordW'(1) << w) - 1)) << lsb;
			end
		endcase
	endfunction

	function automatic logic [WordW-1:0] rand_pixel();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return WordW'(1) << $urandom_range(WordW - 1);
			default: return $urandom;
		endcase
	endfunction

	// Mostly the two real depths, sometimes anything in range
	function automatic logic [DepthW-1:0] rand_depth();
		case ($urandom_range(7))
			0, 1, 2: return DEPTH_16;
			3, 4, 5: return DEPTH_32;
			default: return DepthW'($urandom_range(32));
		endcase
	endfunction

	initial begin
		logic [DepthW-1:0] dep;
		int unsigned       span;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: all masks empty, so every channel reads zero
		send_word('1);
		send_word(32'h1234_5678);
		stop_sending();
		drain_results();

		// Plain 8:8:8:8, byte-wide fields at depth 32
		apply_config(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, DEPTH_32);
		send_word('0);
		send_word('1);
		send_word(32'h1234_5678);
		send_word(32'h8000_0001);
		stop_sending();
		drain_results();

		// 5:6:5 at depth 16, no alpha: upper half ignored, short fields widened
		apply_config(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, '0, DEPTH_16);
		send_word(32'h0000_FFFF);
		send_word(32'hFFFF_0000);
		send_word(32'h0000_0821);
		send_word(32'hABCD_F800);
		stop_sending();
		drain_results();

		// Full-width field, scattered mask and lone top and bottom bits
		apply_config('1, 32'h8000_0001, 32'h8000_0000, 32'h0000_0001, DEPTH_32);
		send_word('0);
		send_word('1);
		send_word(32'h8000_0000);
		send_word(32'h0000_0001);
		send_word(32'h7FFF_FFFE);
		stop_sending();
		drain_results();

		// Depths that decode nothing: zero and one short of a real depth
		apply_config('1, 32'hAAAA_5555, 32'h0000_FFFF, 32'hFFFF_0000, '0);
		send_word('1);
		send_word(32'h5A5A_A5A5);
		stop_sending();
		drain_results();
		apply_config('1, 32'hAAAA_5555, 32'h0000_FFFF, 32'hFFFF_0000, DepthW'(31));
		send_word('1);
		send_word(32'h5A5A_A5A5);
		stop_sending();
		drain_results();

		// Random part: three idle phases, six register settings each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 16;
					recv_stall_pct = 65;
				end
				1: begin
					send_idle_pct  = 65;
					recv_stall_pct = 16;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 6; blk++) begin
				dep  = rand_depth();
				span = (dep == DEPTH_16) ? 16 : WordW;
				apply_config(rand_mask(span), rand_mask(span), rand_mask(span),
					rand_mask(span), dep);
				for (int k = 0; k < 95; k++)
					send_word(rand_pixel());
				stop_sending();
				drain_results();
			end
		end

		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d words never came out", sb.pending()));
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
